>>> sv/trqs_pkg.sv
// Package for the thread ready-queue scheduler: sizes, mode and status codes,
// and the per-cycle action struct passed from the scan unit to the top level.
// No dependencies.
package trqs_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // Request modes
  localparam logic [1:0] MODE_CREATE    = 2'd0;
  localparam logic [1:0] MODE_YIELD_ANY = 2'd1;
  localparam logic [1:0] MODE_YIELD_TO  = 2'd2;
  localparam logic [1:0] MODE_KILL      = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_NOMORE  = 2'd3;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Decision of the scan unit for the current index
  typedef struct packed {
    logic at_end;   // scan has run past its last element
    logic purge;    // queued entry is marked: free it and drop it
    logic take;     // queued entry is the one to switch to
    logic keep;     // queued entry stays in the queue
    logic hit;      // queued entry equals the target id
    logic free_id;  // id at the scan index is not in use
  } scan_act_t;

endpackage

>>> sv/trqs_qstore.sv
// Ready-queue slot storage: one write port and one registered read port.
// Depends on trqs_pkg.
module trqs_qstore
  import trqs_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  id_t  waddr,
  input  id_t  wdata,
  input  id_t  raddr,
  output id_t  rdata
);

  id_t slots_r [MAX_THREADS];
  id_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slots_r[waddr] <= wdata;
    end
    rdata_r <= slots_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/trqs_scan_unit.sv
// Shared compare unit: judges one element per cycle for the id search,
// the purge/compaction pass and the find pass.
// Depends on trqs_pkg.
module trqs_scan_unit
  import trqs_pkg::*;
(
  input  logic [1:0] mode,
  input  cnt_t       idx,
  input  cnt_t       count,
  input  id_t        entry,
  input  id_t        target_id,
  input  id_t        current_id,
  input  logic       entry_killed,
  input  logic       idx_used,
  input  logic       taken,
  output scan_act_t  act
);

  logic hit;
  logic want;

  assign hit = (entry == target_id);

  // Yield-to never takes the running id itself
  assign want = (mode == MODE_YIELD_ANY) ||
                ((mode == MODE_YIELD_TO) && hit && (target_id != current_id));

  always_comb begin
    act.at_end  = (mode == MODE_CREATE) ? (idx == CNT_W'(MAX_THREADS)) : (idx == count);
    act.purge   = entry_killed;
    act.take    = !entry_killed && !taken && want;
    act.keep    = !entry_killed && !(!taken && want);
    act.hit     = hit;
    act.free_id = !idx_used;
  end

endmodule

>>> sv/thread_ready_queue_scheduler.sv
// Top level of the thread ready-queue scheduler: sequencer, state registers
// and output register. Depends on trqs_pkg, trqs_qstore and trqs_scan_unit.
//
// Input channel (in_valid/in_ready, in_mode, in_target_id) carries one request
//   transaction: create, yield to any, yield to target or kill. Output channel
//   (out_valid/out_ready, out_result_id, out_status, out_running_id) returns
//   exactly one result transaction per request. Requests are handled one at a
//   time; in_ready is high only while the sequencer is idle.
// Sequence: one shared compare unit walks one element per cycle. Create scans
//   ids 1 upward, yield makes one compaction pass over the queue, and kill
//   searches the queue (no search if it names the running id). The result
//   then goes from S_FIN into the output register, where S_FIN holds while
//   an earlier result is still waiting. The sequencer then returns to S_IDLE,
//   and only there is the next request taken, so requests do not overlap.
// Reset: rst_n (synchronous, active low) empties the queue, makes id 0 the
//   running thread and marks only id 0 as used; queue slots are not cleared.
// Stall: while out_ready is low and a result is held, the next finished
//   result waits in its last state and no new request is taken.
module thread_ready_queue_scheduler
  import trqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_target_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_result_id,
  output logic [1:0] out_status,
  output logic [3:0] out_running_id
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CREATE = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_FIND   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             mode_r, mode_nxt;
  id_t                    target_r, target_nxt;
  cnt_t                   idx_r, idx_nxt;
  cnt_t                   keep_r, keep_nxt;
  logic                   taken_r, taken_nxt;
  id_t                    next_r, next_nxt;
  cnt_t                   count_r, count_nxt;
  id_t                    current_r, current_nxt;
  logic [MAX_THREADS-1:0] used_r, used_nxt;
  logic [MAX_THREADS-1:0] kill_r, kill_nxt;
  id_t                    res_id_r, res_id_nxt;
  logic [1:0]             res_status_r, res_status_nxt;

  logic                   out_valid_r, out_valid_nxt;
  id_t                    out_result_id_r, out_result_id_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  id_t                    out_running_id_r, out_running_id_nxt;

  logic      q_we;
  id_t       q_waddr;
  id_t       q_wdata;
  id_t       q_entry;
  scan_act_t act;

  // Read address is taken from idx_nxt so the registered slot lines up with idx_r
  trqs_qstore u_qstore (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (idx_nxt[ID_W-1:0]),
    .rdata (q_entry)
  );

  trqs_scan_unit u_scan (
    .mode         (mode_r),
    .idx          (idx_r),
    .count        (count_r),
    .entry        (q_entry),
    .target_id    (target_r),
    .current_id   (current_r),
    .entry_killed (kill_r[q_entry]),
    .idx_used     (used_r[idx_r[ID_W-1:0]]),
    .taken        (taken_r),
    .act          (act)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_result_id  = out_result_id_r;
  assign out_status     = out_status_r;
  assign out_running_id = out_running_id_r;

  always_comb begin
    state_nxt          = state_r;
    mode_nxt           = mode_r;
    target_nxt         = target_r;
    idx_nxt            = idx_r;
    keep_nxt           = keep_r;
    taken_nxt          = taken_r;
    next_nxt           = next_r;
    count_nxt          = count_r;
    current_nxt        = current_r;
    used_nxt           = used_r;
    kill_nxt           = kill_r;
    res_id_nxt         = res_id_r;
    res_status_nxt     = res_status_r;
    out_valid_nxt      = out_valid_r;
    out_result_id_nxt  = out_result_id_r;
    out_status_nxt     = out_status_r;
    out_running_id_nxt = out_running_id_r;
    q_we               = 1'b0;
    q_waddr            = keep_r[ID_W-1:0];
    q_wdata            = q_entry;

    // Drop the held result once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          target_nxt = in_target_id;
          idx_nxt    = (in_mode == MODE_CREATE) ? CNT_W'(1) : '0;
          keep_nxt   = '0;
          taken_nxt  = 1'b0;
          if ((in_mode == MODE_KILL) && (in_target_id == current_r)) begin
            // Kill of the running thread is refused at once
            res_id_nxt     = '0;
            res_status_nxt = ST_INVALID;
            state_nxt      = S_FIN;
          end else if (in_mode == MODE_CREATE) begin
            state_nxt = S_CREATE;
          end else if (in_mode == MODE_KILL) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_PASS;
          end
        end
      end

      S_CREATE: begin
        if (act.at_end) begin
          res_id_nxt     = '0;
          res_status_nxt = ST_NOMORE;
          state_nxt      = S_FIN;
        end else if (act.free_id) begin
          used_nxt[idx_r[ID_W-1:0]] = 1'b1;
          kill_nxt[idx_r[ID_W-1:0]] = 1'b0;
          if (count_r < CNT_W'(MAX_THREADS)) begin
            q_we      = 1'b1;
            q_waddr   = count_r[ID_W-1:0];
            q_wdata   = idx_r[ID_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
          res_id_nxt     = idx_r[ID_W-1:0];
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_PASS: begin
        if (act.at_end) begin
          if (taken_r) begin
            // Old running id goes to the back, in the slot freed by the take
            q_we           = 1'b1;
            q_waddr        = keep_r[ID_W-1:0];
            q_wdata        = current_r;
            count_nxt      = keep_r + CNT_W'(1);
            current_nxt    = next_r;
            res_id_nxt     = next_r;
            res_status_nxt = ST_OK;
          end else begin
            count_nxt = keep_r;
            if ((mode_r == MODE_YIELD_TO) && (target_r == current_r)) begin
              res_id_nxt     = current_r;
              res_status_nxt = ST_OK;
            end else if (mode_r == MODE_YIELD_ANY) begin
              res_id_nxt     = '0;
              res_status_nxt = ST_NONE;
            end else begin
              res_id_nxt     = '0;
              res_status_nxt = ST_INVALID;
            end
          end
          state_nxt = S_FIN;
        end else begin
          if (act.purge) begin
            kill_nxt[q_entry] = 1'b0;
            used_nxt[q_entry] = 1'b0;
          end else if (act.take) begin
            taken_nxt = 1'b1;
            next_nxt  = q_entry;
          end else if (act.keep) begin
            // Compact: write back at the keep pointer, never ahead of the read
            q_we     = 1'b1;
            q_waddr  = keep_r[ID_W-1:0];
            q_wdata  = q_entry;
            keep_nxt = keep_r + CNT_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_FIND: begin
        if (act.at_end) begin
          res_id_nxt     = '0;
          res_status_nxt = ST_INVALID;
          state_nxt      = S_FIN;
        end else if (act.hit) begin
          kill_nxt[target_r] = 1'b1;
          res_id_nxt         = target_r;
          res_status_nxt     = ST_OK;
          state_nxt          = S_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_result_id_nxt  = res_id_r;
          out_status_nxt     = res_status_r;
          out_running_id_nxt = current_r;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      current_r   <= '0;
      used_r      <= MAX_THREADS'(1);
      kill_r      <= '0;
      out_valid_r <= 1'b0;
      taken_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      current_r   <= current_nxt;
      used_r      <= used_nxt;
      kill_r      <= kill_nxt;
      out_valid_r <= out_valid_nxt;
      taken_r     <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r           <= mode_nxt;
    target_r         <= target_nxt;
    idx_r            <= idx_nxt;
    keep_r           <= keep_nxt;
    next_r           <= next_nxt;
    res_id_r         <= res_id_nxt;
    res_status_r     <= res_status_nxt;
    out_result_id_r  <= out_result_id_nxt;
    out_status_r     <= out_status_nxt;
    out_running_id_r <= out_running_id_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_THREADS))
    else $error("ready count exceeds queue depth");

  a_kill_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (kill_r & ~used_r) == '0)
    else $error("kill mark on a free id");

  a_running_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[current_r])
    else $error("running id not marked used");

  a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_result_id_r == '0))
    else $error("nonzero result id with error status");

endmodule
